/* sv/spq_pkg.sv */
`timescale 1ns / 1ps
package spq_pkg;

   localparam int QueueDepth = 16;

   localparam logic [1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [1:0] CMD_PEEK    = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic               used;
      logic signed [31:0] value;
      logic [15:0]        rank;
   } entry_type;

   typedef struct packed {
      logic enq;
      logic deq;
   } ctl_type;

endpackage

/* sv/spq_cell.sv */
`timescale 1ns / 1ps
module spq_cell
   import spq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   input  logic signed [31:0] new_value,
   input  logic [15:0]        new_rank,
   input  entry_type          prev_entry,
   input  logic               prev_keep,
   input  entry_type          next_entry,
   output entry_type          entry,
   output logic               keep
);

   logic               used_ff, used_in;
   logic signed [31:0] value_ff, value_in;
   logic [15:0]        rank_ff, rank_in;

   // an entry of equal or lower rank stays where it is on enqueue
   assign keep = used_ff && (rank_ff <= new_rank);

   always_comb begin
      used_in  = used_ff;
      value_in = value_ff;
      rank_in  = rank_ff;
      if (ctl.enq && !keep) begin
         if (prev_keep) begin
            used_in  = 1'b1;
            value_in = new_value;
            rank_in  = new_rank;
         end else begin
            used_in  = prev_entry.used;
            value_in = prev_entry.value;
            rank_in  = prev_entry.rank;
         end
      end else if (ctl.deq) begin
         used_in  = next_entry.used;
         value_in = next_entry.value;
         rank_in  = next_entry.rank;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rank_ff  <= rank_in;
   end

   assign entry = '{used: used_ff, value: value_ff, rank: rank_ff};

endmodule

/* sv/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// the response beat is registered: it comes in the cycle after start is taken
// throughput: one command per cycle; every cell compares and shifts in the same cycle
// busy stays low, since each command finishes in the cycle it is taken
// reset empties the queue (all used bits clear) and drops any pending response
// the receiver cannot stall: rsp_valid is a one-cycle strobe
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_item_value,
   input  logic [15:0]        req_item_rank,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_out_value,
   output logic [15:0]        rsp_out_rank,
   output logic [1:0]         rsp_status
);

   entry_type cells   [QueueDepth];
   logic      keeps   [QueueDepth];
   entry_type prev_e  [QueueDepth];
   logic      prev_k  [QueueDepth];
   entry_type next_e  [QueueDepth];

   logic    accept, empty, full;
   ctl_type ctl;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [15:0]        rsp_rank_ff, rsp_rank_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign empty  = !cells[0].used;
   assign full   = cells[QueueDepth-1].used;

   assign ctl.enq = accept && (req_cmd == CMD_ENQUEUE) && !full;
   assign ctl.deq = accept && (req_cmd == CMD_DEQUEUE) && !empty;

   for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign prev_e[i] = '0;
         assign prev_k[i] = 1'b1;
      end else begin : g_body
         assign prev_e[i] = cells[i-1];
         assign prev_k[i] = keeps[i-1];
      end
      if (i == QueueDepth - 1) begin : g_tail
         assign next_e[i] = '0;
      end else begin : g_mid
         assign next_e[i] = cells[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_value  (req_item_value),
         .new_rank   (req_item_rank),
         .prev_entry (prev_e[i]),
         .prev_keep  (prev_k[i]),
         .next_entry (next_e[i]),
         .entry      (cells[i]),
         .keep       (keeps[i])
      );
   end

   always_comb begin
      rsp_valid_in  = accept;
      rsp_value_in  = '0;
      rsp_rank_in   = '0;
      rsp_status_in = STATUS_OK;
      case (req_cmd)
         CMD_ENQUEUE: begin
            if (full) rsp_status_in = STATUS_OVERFLOW;
         end
         CMD_DEQUEUE, CMD_PEEK: begin
            if (empty) begin
               rsp_status_in = STATUS_UNDERFLOW;
            end else begin
               rsp_value_in = cells[0].value;
               rsp_rank_in  = cells[0].rank;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_rank  = rsp_rank_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
   import spq_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int WatchdogLimit = 400;
   localparam int PhaseCount = 10;
   localparam int PhaseItems = 100;

   typedef struct packed {
      logic signed [31:0] value;
      logic [15:0]        rank;
      logic [1:0]         status;
   } head_reply_type;

   // sorted copy of the queue; works out the reply to each accepted command
   class head_predictor;
      logic signed [31:0] held_value[QueueDepth];
      logic [15:0]        held_rank[QueueDepth];
      int                 fill;
      head_reply_type     awaited_replies[$];
      int                 errors;
      int                 checked;
      int                 max_fill;
      int                 cmd_seen[4];
      int                 overflows;
      int                 underflows;

      function new();
         fill = 0;
         errors = 0;
         checked = 0;
         max_fill = 0;
         overflows = 0;
         underflows = 0;
         foreach (cmd_seen[k]) cmd_seen[k] = 0;
      endfunction

      function int pending();
         return awaited_replies.size();
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      function void note_command(logic [1:0] cmd, logic signed [31:0] val,
                                 logic [15:0] rank);
         head_reply_type reply;
         int pos;
         int i;
         reply = '0;
         cmd_seen[cmd]++;
         case (cmd)
            CMD_ENQUEUE: begin
               if (fill >= QueueDepth) begin
                  reply.status = STATUS_OVERFLOW;
                  overflows++;
               end else begin
                  // ties go behind existing entries of the same rank
                  pos = 0;
                  while (pos < fill && held_rank[pos] <= rank) pos++;
                  for (i = fill; i > pos; i--) begin
                     held_value[i] = held_value[i-1];
                     held_rank[i] = held_rank[i-1];
                  end
                  held_value[pos] = val;
                  held_rank[pos] = rank;
                  fill++;
                  if (fill > max_fill) max_fill = fill;
               end
            end
            CMD_DEQUEUE, CMD_PEEK: begin
               if (fill == 0) begin
                  reply.status = STATUS_UNDERFLOW;
                  underflows++;
               end else begin
                  reply.value = held_value[0];
                  reply.rank = held_rank[0];
                  if (cmd == CMD_DEQUEUE) begin
                     for (i = 0; i + 1 < fill; i++) begin
                        held_value[i] = held_value[i+1];
                        held_rank[i] = held_rank[i+1];
                     end
                     fill--;
                  end
               end
            end
            default: ;
         endcase
         awaited_replies.push_back(reply);
      endfunction

      task check_reply(logic signed [31:0] val, logic [15:0] rank, logic [1:0] status);
         head_reply_type want;
         if (awaited_replies.size() == 0) begin
            report_mismatch($sformatf(
               "reply with nothing outstanding (value %0d rank %0d status %0d)",
               val, rank, status));
         end else begin
            want = awaited_replies.pop_front();
            checked++;
            if (val !== want.value)
               report_mismatch($sformatf("value %0d, want %0d", val, want.value));
            if (rank !== want.rank)
               report_mismatch($sformatf("rank %0d, want %0d", rank, want.rank));
            if (status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", status, want.status));
         end
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_cmd;
   logic signed [31:0] req_item_value;
   logic [15:0]        req_item_rank;
   logic               rsp_valid;
   logic signed [31:0] rsp_out_value;
   logic [15:0]        rsp_out_rank;
   logic [1:0]         rsp_status;

   head_predictor model = new();
   int quiet_cycles = 0;

   sorted_priority_queue dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_item_value (req_item_value),
      .req_item_rank  (req_item_rank),
      .rsp_valid      (rsp_valid),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_rank   (rsp_out_rank),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // reply is checked before the new command is noted, so a reply is matched only to a command from an earlier cycle
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) model.check_reply(rsp_out_value, rsp_out_rank, rsp_status);
         if (start && !busy) model.note_command(req_cmd, req_item_value, req_item_rank);
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task send(logic [1:0] cmd, logic signed [31:0] val, logic [15:0] rank);
      start <= 1'b1;
      req_cmd <= cmd;
      req_item_value <= val;
      req_item_rank <= rank;
      do @(posedge clock); while (busy);
   endtask

   // idle with junk on the request fields
   task pause(int cycles);
      start <= 1'b0;
      req_cmd <= 2'($urandom());
      req_item_value <= $urandom();
      req_item_rank <= 16'($urandom());
      repeat (cycles) @(posedge clock);
   endtask

   task drain();
      pause(1);
      while (model.pending() != 0) @(posedge clock);
   endtask

   function logic [15:0] pick_rank();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2, 3, 4, 5: return 16'($urandom_range(0, 7));
         6:       return 16'($urandom_range(16'hFFF8, 16'hFFFF));
         default: return 16'($urandom());
      endcase
   endfunction

   function logic signed [31:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return -32'sd1;
         3:       return 32'sd0;
         default: return $urandom();
      endcase
   endfunction

   function logic [1:0] pick_cmd(int enq_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) return CMD_UNUSED;
      if (roll < 2 + enq_pct) return CMD_ENQUEUE;
      return ($urandom_range(0, 2) == 0) ? CMD_PEEK : CMD_DEQUEUE;
   endfunction

   // one phase of random traffic in bursts; enq_pct steers the fill level
   task run_phase(int enq_pct, bit no_gaps);
      int left;
      int burst;
      left = PhaseItems;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         if (burst > left) burst = left;
         repeat (burst) send(pick_cmd(enq_pct), pick_value(), pick_rank());
         left -= burst;
         if (!no_gaps && $urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
      end
   endtask

   initial begin
      int p;
      int n;
      reset <= 1'b1;
      start <= 1'b0;
      req_cmd <= CMD_ENQUEUE;
      req_item_value <= '0;
      req_item_rank <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty queue cases and the unused command
      send(CMD_DEQUEUE, 32'sd5, 16'd5);
      send(CMD_PEEK, 32'sd6, 16'd6);
      send(CMD_UNUSED, 32'sd7, 16'd7);
      // fill to the brim with extremes and equal ranks
      send(CMD_ENQUEUE, 32'sh7FFF_FFFF, 16'hFFFF);
      send(CMD_ENQUEUE, 32'sh8000_0000, 16'h0000);
      send(CMD_ENQUEUE, 32'sd0, 16'h0000);
      send(CMD_ENQUEUE, -32'sd1, 16'h8000);
      send(CMD_ENQUEUE, 32'sh5555_5555, 16'hFFFF);
      send(CMD_ENQUEUE, 32'shAAAA_AAAA, 16'h7FFF);
      pause(2);
      for (n = 0; n < 10; n++) send(CMD_ENQUEUE, 32'sd100 + n, 16'(n % 3));
      // full queue: dropped enqueue, then head checks
      send(CMD_ENQUEUE, 32'sd12345, 16'h0000);
      send(CMD_PEEK, 32'sd0, 16'd0);
      send(CMD_UNUSED, 32'sd0, 16'd0);
      send(CMD_DEQUEUE, 32'sd0, 16'd0);
      send(CMD_DEQUEUE, 32'sd0, 16'd0);
      drain();

      for (p = 0; p < PhaseCount; p++) begin
         case (p % 5)
            0:       run_phase(45, 1'b0);
            1:       run_phase(75, 1'b0);
            2:       run_phase(20, 1'b1);
            3:       run_phase(60, 1'b1);
            default: run_phase(35, 1'b0);
         endcase
         // after each odd-numbered phase, hold the sender until every outstanding reply is back
         if (p % 2 == 1) drain();
      end

      drain();
      repeat (5) @(posedge clock);
      $display("commands: %0d enqueue, %0d dequeue, %0d peek, %0d unused",
               model.cmd_seen[CMD_ENQUEUE], model.cmd_seen[CMD_DEQUEUE],
               model.cmd_seen[CMD_PEEK], model.cmd_seen[CMD_UNUSED]);
      $display("%0d overflow, %0d underflow; replies checked: %0d, deepest fill %0d of %0d",
               model.overflows, model.underflows, model.checked, model.max_fill,
               QueueDepth);
      $display("mismatches %0d", model.errors);
      if (model.errors == 0 && model.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
